### hdl/lfab_pkg.sv
// shared constants, types and helpers for the line folder
package lfab_pkg;

  localparam int CHAR_W    = 8;
  localparam int CNT_W     = 7;
  localparam int LIMIT_W   = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [CNT_W-1:0]   OVERLONG    = 7'd127;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd2;

  localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'h0a;

  typedef struct packed {
    logic accept;
    logic emit_rd;
    logic emit_load;
    logic tail_load;
    logic copy_rd;
    logic copy_wr;
    logic copy_fin;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic plan_held_nz;
    logic plan_tail;
    logic emit_last;
    logic tail_en;
    logic copy_en;
    logic copy_more;
  } status_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

endpackage

### hdl/lfab_ctrl.sv
// sequencer for accept, held-text emission, fold newline and remainder copy
module lfab_ctrl import lfab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    EMIT_RD,
    EMIT_WR,
    TAIL,
    COPY
  } state_t;

  state_t state;
  state_t state_next;
  logic   pend;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.plan_held_nz) begin
            state_next = EMIT_RD;
          end else if (sts.plan_tail) begin
            state_next = TAIL;
          end
        end
      end
      EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = EMIT_WR;
      end
      EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (!sts.emit_last) begin
            state_next = EMIT_RD;
          end else if (sts.tail_en) begin
            state_next = TAIL;
          end else begin
            state_next = IDLE;
          end
        end
      end
      TAIL: begin
        if (sts.out_free) begin
          cmd.tail_load = 1'b1;
          state_next    = sts.copy_en ? COPY : IDLE;
        end
      end
      COPY: begin
        cmd.copy_rd = sts.copy_more;
        cmd.copy_wr = pend;
        if (!sts.copy_more && !pend) begin
          cmd.copy_fin = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= cmd.copy_rd;
    end
  end

endmodule

### hdl/lfab_datapath.sv
// segment store, line state, fold decision and output register
module lfab_datapath import lfab_pkg::*; #(
  parameter int BUFFER_DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic [CHAR_W-1:0]  in_ch,
  input  logic               in_flush,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_last
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

  logic [CHAR_W-1:0]  store [BUFFER_DEPTH];
  logic [CHAR_W-1:0]  rdata;

  logic [LIMIT_W-1:0] limit;
  logic [CNT_W-1:0]   count, count_next;
  logic [AW-1:0]      fold_pos, fold_pos_next;
  logic               has_fp, has_fp_next;
  logic               in_run, in_run_next;
  logic               at_start, at_start_next;
  logic               dropping, dropping_next;

  logic [CNT_W-1:0]   held_n;
  logic               tail_en;
  logic [CHAR_W-1:0]  tail_char;
  logic               copy_en;
  logic [CNT_W-1:0]   copy_beg;
  logic [CNT_W-1:0]   copy_end;
  logic [CNT_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   wr_ptr;
  logic               skipping;

  logic               blank_in;
  logic               overlong;
  logic [CNT_W-1:0]   cnt_c;
  logic [CNT_W-1:0]   cnt_n;
  logic [CNT_W-1:0]   lim;
  logic [AW-1:0]      fp_s;
  logic               hfp_s;
  logic               run_s;
  logic               start_s;
  logic               fold_ok;

  logic [CNT_W-1:0]   plan_held;
  logic               plan_tail;
  logic [CHAR_W-1:0]  plan_tchar;
  logic               plan_copy;
  logic               acc_we;

  logic               rd_blank;
  logic               keep;

  assign blank_in = is_blank(in_ch);
  assign overlong = (count == OVERLONG);
  assign cnt_c    = (count >= DEPTH_C) ? (DEPTH_C - CNT_W'(1)) : count;
  assign cnt_n    = cnt_c + CNT_W'(1);

  always_comb begin
    if (limit < LIMIT_MIN) begin
      lim = LIMIT_MIN;
    end else if (limit > DEPTH_C) begin
      lim = DEPTH_C;
    end else begin
      lim = limit;
    end
  end

  // blank-run tracking for the incoming character
  always_comb begin
    fp_s    = fold_pos;
    hfp_s   = has_fp;
    run_s   = in_run;
    start_s = at_start;
    if (blank_in) begin
      if (!in_run && !at_start) begin
        fp_s  = cnt_c[AW-1:0];
        hfp_s = 1'b1;
      end
      run_s = 1'b1;
    end else begin
      run_s   = 1'b0;
      start_s = 1'b0;
    end
  end

  assign fold_ok = hfp_s && (CNT_W'(fp_s) < cnt_n);

  always_comb begin
    count_next    = count;
    fold_pos_next = fold_pos;
    has_fp_next   = has_fp;
    in_run_next   = in_run;
    at_start_next = at_start;
    dropping_next = dropping;
    plan_held     = '0;
    plan_tail     = 1'b0;
    plan_tchar    = CH_NL;
    plan_copy     = 1'b0;
    acc_we        = 1'b0;
    if (in_flush || (in_ch == CH_NL)) begin
      plan_held     = overlong ? '0 : count;
      plan_tail     = !in_flush;
      count_next    = '0;
      fold_pos_next = '0;
      has_fp_next   = 1'b0;
      in_run_next   = 1'b0;
      at_start_next = 1'b1;
      dropping_next = 1'b0;
    end else if (dropping && blank_in) begin
      plan_held = '0;
    end else if (overlong) begin
      dropping_next = 1'b0;
      plan_tail     = 1'b1;
      if (blank_in && !at_start) begin
        count_next    = '0;
        has_fp_next   = 1'b0;
        in_run_next   = 1'b0;
        dropping_next = 1'b1;
      end else begin
        plan_tchar = in_ch;
        if (!blank_in) begin
          at_start_next = 1'b0;
        end
      end
    end else begin
      acc_we        = 1'b1;
      dropping_next = 1'b0;
      if (cnt_n >= lim) begin
        if (fold_ok) begin
          plan_held     = CNT_W'(fp_s);
          plan_tail     = 1'b1;
          plan_copy     = 1'b1;
          fold_pos_next = '0;
          has_fp_next   = 1'b0;
          in_run_next   = 1'b0;
          at_start_next = 1'b0;
        end else begin
          plan_held     = cnt_n;
          count_next    = OVERLONG;
          fold_pos_next = fp_s;
          has_fp_next   = 1'b0;
          in_run_next   = 1'b0;
          at_start_next = start_s;
        end
      end else begin
        count_next    = cnt_n;
        fold_pos_next = fp_s;
        has_fp_next   = hfp_s;
        in_run_next   = run_s;
        at_start_next = start_s;
      end
    end
  end

  assign rd_blank = is_blank(rdata);
  assign keep     = !(skipping && rd_blank);

  always_ff @(posedge clk) begin
    if (cmd.accept && acc_we) begin
      store[cnt_c[AW-1:0]] <= in_ch;
    end else if (cmd.copy_wr && keep) begin
      store[wr_ptr[AW-1:0]] <= rdata;
    end
    if (cmd.emit_rd || cmd.copy_rd) begin
      rdata <= store[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      count     <= '0;
      fold_pos  <= '0;
      has_fp    <= 1'b0;
      in_run    <= 1'b0;
      at_start  <= 1'b1;
      dropping  <= 1'b0;
      tail_en   <= 1'b0;
      copy_en   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (cmd.accept) begin
        count    <= count_next;
        fold_pos <= fold_pos_next;
        has_fp   <= has_fp_next;
        in_run   <= in_run_next;
        at_start <= at_start_next;
        dropping <= dropping_next;
        tail_en  <= plan_tail;
        copy_en  <= plan_copy;
      end
      if (cmd.copy_wr && keep) begin
        if (rd_blank && !in_run) begin
          fold_pos <= wr_ptr[AW-1:0];
          has_fp   <= 1'b1;
        end
        in_run <= rd_blank;
      end
      if (cmd.copy_fin) begin
        count    <= wr_ptr;
        dropping <= (wr_ptr == '0);
      end
      if (cmd.emit_load || cmd.tail_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held_n    <= plan_held;
      tail_char <= plan_tchar;
      copy_beg  <= CNT_W'(fp_s) + CNT_W'(1);
      copy_end  <= cnt_n;
      rd_ptr    <= '0;
    end
    if (cmd.emit_load || cmd.copy_rd) begin
      rd_ptr <= rd_ptr + CNT_W'(1);
    end
    if (cmd.tail_load) begin
      rd_ptr   <= copy_beg;
      wr_ptr   <= '0;
      skipping <= 1'b1;
    end
    if (cmd.copy_wr && keep) begin
      skipping <= 1'b0;
      wr_ptr   <= wr_ptr + CNT_W'(1);
    end
    if (cmd.emit_load) begin
      out_char <= rdata;
      out_last <= sts.emit_last && !tail_en;
    end else if (cmd.tail_load) begin
      out_char <= tail_char;
      out_last <= 1'b1;
    end
  end

  assign sts.out_free     = !out_valid || out_ready;
  assign sts.plan_held_nz = (plan_held != '0);
  assign sts.plan_tail    = plan_tail;
  assign sts.emit_last    = ((rd_ptr + CNT_W'(1)) == held_n);
  assign sts.tail_en      = tail_en;
  assign sts.copy_en      = copy_en;
  assign sts.copy_more    = (rd_ptr < copy_end);

endmodule

### hdl/line_fold_at_blank.sv
// top level of the blank-aware line folder
//
// characters enter on the s_axis channel, one per transaction: tdata holds
// the character, tuser marks end of text (flush). folded text leaves on the
// m_axis channel one character per transaction; tlast marks the final
// character caused by one input transaction. line_limit must be written
// through cfg_valid/cfg_data (always ready) only while the block is idle;
// the block itself does not enforce this. an input that produces no
// character leaves the block ready; a single echoed character or newline
// is loaded from the TAIL state. every held character that is emitted
// passes through EMIT_RD and EMIT_WR because the segment store has one
// registered read port; after a fold the kept remainder moves to the front
// of the store at one character per cycle before the next input is taken.
// the output register lets the next input be taken while the last result
// waits; if the receiver stalls, emission pauses on the held character.
// reset sets the limit to 64 and starts an empty line; no clearing pass
// is needed.
module line_fold_at_blank import lfab_pkg::*; #(
  parameter int BUFFER_DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [CHAR_W-1:0]  s_axis_tdata,  // ch
  input  logic               s_axis_tuser,  // flush
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [CHAR_W-1:0]  m_axis_tdata,  // out_char
  output logic               m_axis_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  lfab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfab_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_ch     (s_axis_tdata),
    .in_flush  (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.emit_rd, cmd.emit_load, cmd.tail_load}))
    else $error("conflicting datapath commands");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load || cmd.tail_load) |-> sts.out_free)
    else $error("output register overwritten");

  a_copy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.tail_load && sts.copy_en) |=> !s_axis_tready)
    else $error("input taken during remainder copy");

  a_quiet_item_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !sts.plan_held_nz && !sts.plan_tail) |=> s_axis_tready)
    else $error("silent transaction did not return to ready");

endmodule

### tb/line_fold_at_blank_tb.sv
// testbench for line_fold_at_blank: directed and random text against a folding predictor
module line_fold_at_blank_tb;
  import lfab_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } folded_char_t;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [CHAR_W-1:0]  s_axis_tdata;  // ch
  logic               s_axis_tuser;  // flush
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [CHAR_W-1:0]  m_axis_tdata;  // out_char
  logic               m_axis_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  // predictor state
  logic [CHAR_W-1:0]  seg_buf [DEPTH_DEF];
  logic [CNT_W-1:0]   seg_len;
  logic [5:0]         fold_at;
  bit                 has_fold;
  bit                 in_blank;
  bit                 line_start;
  bit                 drop_run;
  logic [LIMIT_W-1:0] limit_reg;

  folded_char_t folded_chars_q[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_left = 0;
  int chars_sent = 0;
  int chars_checked = 0;
  int mismatches = 0;
  int settings_done = 0;
  int cycle_count = 0;

  line_fold_at_blank dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit_char(input logic [CHAR_W-1:0] c);
    folded_chars_q.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void emit_held(input int count);
    for (int k = 0; k < count && k < DEPTH_DEF; k++) emit_char(seg_buf[k]);
  endfunction

  function automatic void start_line();
    seg_len    = '0;
    fold_at    = '0;
    has_fold   = 1'b0;
    in_blank   = 1'b0;
    line_start = 1'b1;
    drop_run   = 1'b0;
  endfunction

  function automatic void predict_fold(input logic [CHAR_W-1:0] c, input logic fl);
    int lim;
    int cnt;
    int j;
    int rem;
    int base;
    bit overlong;
    bit blank;
    bit b;
    base = folded_chars_q.size();
    lim = int'(limit_reg);
    if (lim < 2) lim = 2;
    if (lim > DEPTH_DEF) lim = DEPTH_DEF;
    overlong = (seg_len == OVERLONG);
    blank = (c == CH_SP) || (c == CH_TAB);
    if (fl) begin
      if (!overlong) emit_held(int'(seg_len));
      start_line();
    end else if (c == CH_NL) begin
      if (!overlong) emit_held(int'(seg_len));
      emit_char(CH_NL);
      start_line();
    end else if (drop_run && blank) begin
      // blank right after a fold is dropped
    end else if (overlong) begin
      drop_run = 1'b0;
      if (blank && !line_start) begin
        emit_char(CH_NL);
        seg_len  = '0;
        has_fold = 1'b0;
        in_blank = 1'b0;
        drop_run = 1'b1;
      end else begin
        emit_char(c);
        if (!blank) line_start = 1'b0;
      end
    end else begin
      cnt = int'(seg_len);
      drop_run = 1'b0;
      if (cnt >= DEPTH_DEF) cnt = DEPTH_DEF - 1;
      seg_buf[cnt] = c;
      cnt++;
      if (blank) begin
        if (!in_blank && !line_start) begin
          fold_at  = 6'(cnt - 1);
          has_fold = 1'b1;
        end
        in_blank = 1'b1;
      end else begin
        in_blank   = 1'b0;
        line_start = 1'b0;
      end
      if (cnt >= lim) begin
        if (has_fold && int'(fold_at) < cnt) begin
          emit_held(int'(fold_at));
          emit_char(CH_NL);
          // skip the rest of the blank run and move the tail to the front
          j = int'(fold_at) + 1;
          while (j < cnt && (seg_buf[j] == CH_SP || seg_buf[j] == CH_TAB)) j++;
          rem = 0;
          for (int k = j; k < cnt; k++) begin
            seg_buf[rem] = seg_buf[k];
            rem++;
          end
          has_fold   = 1'b0;
          in_blank   = 1'b0;
          line_start = 1'b0;
          fold_at    = '0;
          for (int k = 0; k < rem; k++) begin
            b = (seg_buf[k] == CH_SP) || (seg_buf[k] == CH_TAB);
            if (b && !in_blank) begin
              fold_at  = 6'(k);
              has_fold = 1'b1;
            end
            in_blank = b;
          end
          drop_run = (rem == 0);
          cnt = rem;
        end else begin
          emit_held(cnt);
          has_fold = 1'b0;
          in_blank = 1'b0;
          cnt = int'(OVERLONG);
        end
      end
      seg_len = CNT_W'(cnt);
    end
    if (folded_chars_q.size() > base) folded_chars_q[folded_chars_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic fl);
    while (tx_idle && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= fl;
    do @(posedge clk); while (!s_axis_tready);
    predict_fold(c, fl);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (folded_chars_q.size() != 0) @(posedge clk);
    // a fold may still be moving the tail after its last character left
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = v;
    settings_done++;
  endtask

  task automatic test_edges();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_fold();
    write_limit(7'd4);
    send_text("ab cd\n");
  endtask

  task automatic test_overlong();
    // leading blanks fill the line, then a word runs on and a blank breaks it
    send_text("     x  yz\n");
  endtask

  task automatic test_limit_drop();
    write_limit(7'd64);
    send_text("ab cd e");
    write_limit(7'd3);
    send_text("f");
  endtask

  task automatic test_backpressure();
    logic [CHAR_W-1:0] c;
    write_limit(7'd6);
    hold_left = 600;
    for (int i = 0; i < 45; i++) begin
      c = ($urandom_range(3) == 0) ? CH_SP : CHAR_W'($urandom_range(8'h61, 8'h7a));
      send_char(c, 1'b0);
    end
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_items, input bit idle);
    int sent;
    int kind;
    int wlen;
    int blanks;
    logic [CHAR_W-1:0] c;
    write_limit(lim);
    tx_idle = idle;
    rx_idle = idle;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(19);
      if (kind == 0) begin
        send_char(CH_NL, 1'b0);
        sent++;
        blanks = $urandom_range(2);
        for (int i = 0; i < blanks; i++) begin
          send_char($urandom_range(1) ? CH_SP : CH_TAB, 1'b0);
          sent++;
        end
      end else if (kind == 1) begin
        send_char(CHAR_W'($urandom), 1'b1);
        sent++;
      end else if (kind < 4) begin
        send_char(CHAR_W'($urandom), 1'b0);
        sent++;
      end else begin
        wlen = ($urandom_range(11) == 0) ? $urandom_range(10, 66) : $urandom_range(1, 8);
        for (int i = 0; i < wlen; i++) begin
          do c = CHAR_W'($urandom); while (c == CH_SP || c == CH_TAB || c == CH_NL);
          send_char(c, 1'b0);
          sent++;
        end
        blanks = $urandom_range(1, 3);
        for (int i = 0; i < blanks; i++) begin
          send_char($urandom_range(1) ? CH_SP : CH_TAB, 1'b0);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    run_phase(7'd2, 22, 1'b1);
    run_phase(7'd64, 22, 1'b0);
    run_phase(7'd0, 22, 1'b1);
    run_phase(7'd127, 22, 1'b1);
    run_phase(7'd1, 22, 1'b1);
    run_phase(7'd65, 22, 1'b1);
    run_phase(LIMIT_W'($urandom_range(3, 20)), 22, 1'b1);
    run_phase(LIMIT_W'($urandom_range(3, 40)), 22, 1'b1);
  endtask

  // output side: random stalls plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !rx_idle || ($urandom_range(99) >= 23);
      end
    end
  end

  // compare each output transaction with the oldest expected character
  always @(posedge clk) begin : check_output
    folded_char_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (folded_chars_q.size() == 0) begin
        $error("out_char: expected none, actual 0x%02h", m_axis_tdata);
        mismatches++;
      end else begin
        want = folded_chars_q.pop_front();
        chars_checked++;
        if (m_axis_tdata !== want.ch) begin
          $error("out_char: expected 0x%02h, actual 0x%02h", want.ch, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[line_fold_at_blank] ERROR");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    limit_reg     = LIMIT_RESET;
    start_line();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_fold();
    test_overlong();
    test_limit_drop();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (folded_chars_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d input and %0d output transactions over %0d limit settings",
             chars_sent, chars_checked, settings_done);
    $display("limits 0, 1, 2, 64, 65 and 127 were used, with one long output stall");
    if (mismatches == 0 && folded_chars_q.size() == 0) begin
      $display("[line_fold_at_blank] OK");
    end else begin
      $display("[line_fold_at_blank] ERROR");
    end
    $finish;
  end

endmodule
